[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ISQRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ISQRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/isqrt_pkg.sv]
// Shared widths, constants and controller-to-datapath types of the square root block.
// No dependencies.
package isqrt_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int ROOT_W     = 17;
  // Root bits produced, two operand bits consumed per step.
  localparam int ROOT_BITS  = (DATA_WIDTH + 1) / 2;
  localparam int OP_W       = 2 * ROOT_BITS;
  localparam int REM_W      = ROOT_BITS + 2;
  localparam int CNT_W      = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_BITS - 1);
  localparam logic signed [ROOT_W-1:0] NEG_ROOT = '1;

  typedef struct packed {
    logic load;      // capture a new operand, clear root and remainder
    logic step;      // one root bit
    logic load_out;  // move the finished root into the output register
  } isqrt_cmd_t;

endpackage

[rtl/isqrt_if.sv]
// Request and response channels of the square root block.
// Depends on isqrt_pkg.
interface isqrt_req_if import isqrt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

interface isqrt_rsp_if import isqrt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ROOT_W-1:0] root;

  modport source (output valid, root, input ready);
  modport sink   (input valid, root, output ready);
endinterface

[rtl/isqrt_ctrl.sv]
// Controller of the square root block: request handshake, step count, output valid.
// Depends on isqrt_pkg.
module isqrt_ctrl import isqrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output isqrt_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + CNT_W'(1);
        if (cnt_q == LAST_STEP) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // wait for the output register to drain
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/isqrt_dp.sv]
// Datapath of the square root block: digit-by-digit root, one bit per step.
// Depends on isqrt_pkg.
module isqrt_dp import isqrt_pkg::*; (
  input  logic                      clk_i,
  input  isqrt_cmd_t                cmd_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic signed [ROOT_W-1:0]  root_o
);

  logic [OP_W-1:0]          op_q, op_d;
  logic [REM_W-1:0]         rem_q, rem_d;
  logic [ROOT_BITS-1:0]     root_q, root_d;
  logic                     neg_q, neg_d;
  logic signed [ROOT_W-1:0] out_q, out_d;
  logic [REM_W-1:0]         rem_sh;
  logic [REM_W-1:0]         trial;
  logic                     fits;

  // Shift the next two operand bits into the remainder and test root*4+1 against it.
  assign rem_sh = {rem_q[REM_W-3:0], op_q[OP_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    op_d   = op_q;
    rem_d  = rem_q;
    root_d = root_q;
    neg_d  = neg_q;
    out_d  = out_q;
    if (cmd_i.load) begin
      op_d   = OP_W'(value_i[DATA_WIDTH-1:0]);
      neg_d  = value_i[DATA_WIDTH-1];
      rem_d  = '0;
      root_d = '0;
    end
    if (cmd_i.step) begin
      op_d = op_q << 2;
      if (fits) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_BITS-2:0], 1'b0};
      end
    end
    if (cmd_i.load_out) begin
      out_d = neg_q ? NEG_ROOT : ROOT_W'(root_q);
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
  end

  assign root_o = out_q;

endmodule

[rtl/integer_square_root.sv]
// Top level of the integer square root block: controller, datapath, checks.
// Depends on isqrt_pkg, isqrt_if, isqrt_ctrl, isqrt_dp and assert_macros.svh.
//
//   channel  dir  payload         meaning
//   req_i    in   value  [31:0]   signed operand
//   rsp_o    out  root   [16:0]   floor root, all ones for a negative operand
//
// A request is accepted in the idle state, then each root bit goes through the shared
// compare-subtract, one step per bit, and the flush state loads the output register.
// A new request is taken once the previous one has reached the output register.
// A stalled response holds the block in its flush state until the register drains.
// Reset clears the controller only; there is no per-item state to clear.
`include "assert_macros.svh"

module integer_square_root import isqrt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  isqrt_req_if.sink         req_i,
  isqrt_rsp_if.source       rsp_o
);

  isqrt_cmd_t cmd;

  isqrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  isqrt_dp u_dp (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .value_i (req_i.value),
    .root_o  (rsp_o.root)
  );

  `ISQRT_ASSERT(a_busy_after_req, req_i.valid && req_i.ready |=> !req_i.ready,
                "request taken while a root is still in progress")
  `ISQRT_ASSERT(a_neg_all_ones, rsp_o.valid && rsp_o.root[ROOT_W-1] |-> rsp_o.root == NEG_ROOT,
                "negative response is not all ones")
  `ISQRT_ASSERT(a_one_cmd, $onehot0({cmd.load, cmd.step, cmd.load_out}),
                "controller issued more than one datapath command")
  `ISQRT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !rsp_o.valid,
                       "response valid during reset")

endmodule

[bench/integer_square_root_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for integer_square_root: random and corner operands, checked roots.
// Depends on isqrt_pkg, the isqrt_req_if / isqrt_rsp_if channels and the block's RTL.

module integer_square_root_test;
  import isqrt_pkg::*;

  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_COIN,
    SINK_SPARSE
  } sink_mode_e;

  localparam int RANDOM_OPERANDS = 800;
  localparam int HOLD_AFTER      = 250;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 40;

  logic clk;
  logic rst_n;

  isqrt_req_if req_if ();
  isqrt_rsp_if rsp_if ();

  integer_square_root u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic signed [VALUE_W-1:0] pending_values[$];
  logic signed [ROOT_W-1:0]  expected_roots[$];

  logic       req_taken;
  int         gap_left;
  int         burst_left;
  sink_mode_e sink_mode;
  int         mode_left;
  int         hold_left;
  logic       hold_done;
  int         roots_checked;
  int         negative_ops;
  int         error_count;

  // Floor root built one bit at a time, squares kept in 64 bits.
  function automatic logic signed [ROOT_W-1:0] floor_sqrt(logic signed [VALUE_W-1:0] v);
    logic [63:0] acc;
    logic [63:0] trial;
    logic [63:0] operand;
    if (v < 0) return NEG_ROOT;
    acc     = '0;
    operand = 64'(unsigned'(v));
    for (int b = 31; b >= 0; b--) begin
      trial = acc | (64'd1 << b);
      if (trial * trial <= operand) acc = trial;
    end
    return acc[ROOT_W-1:0];
  endfunction

  always #2 clk = ~clk;

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      req_if.value <= '0;
    end else if (!req_if.valid || req_taken) begin
      req_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pending_values.size() > 0) begin
        req_if.valid <= 1'b1;
        req_if.value <= pending_values[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response sink: changes stall pattern now and then, one long hold-off mid-run.
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (!hold_done && roots_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          sink_mode = sink_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(8, 80);
        end else begin
          mode_left--;
        end
        case (sink_mode)
          SINK_ALWAYS: rsp_if.ready <= 1'b1;
          SINK_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
          default:     rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Accepted requests feed the expected roots; accepted responses are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        expected_roots.push_back(floor_sqrt(req_if.value));
        if (req_if.value < 0) negative_ops++;
        void'(pending_values.pop_front());
        req_taken = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_roots.size() == 0) begin
          $error("root: expected none, got %0d", rsp_if.root);
          error_count++;
        end else begin
          if (rsp_if.root !== expected_roots[0]) begin
            $error("root: expected %0d, got %0d", expected_roots[0], rsp_if.root);
            error_count++;
          end
          void'(expected_roots.pop_front());
        end
        roots_checked++;
      end
    end
  end

  initial begin
    static logic signed [VALUE_W-1:0] corner_values[] = '{
      32'sd0, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd8, 32'sd15, 32'sd16, 32'sd24,
      32'sd25, 32'sd99, 32'sd100, 32'sd65535, 32'sd65536, 32'sd1073741823,
      32'sd1073741824, 32'sd2147395599, 32'sd2147395600, 32'sd2147483647,
      32'h5555_5555, -32'sd1, -32'sd2, 32'h8000_0000, 32'hAAAA_AAAA
    };
    logic [31:0] k;
    logic [31:0] v;

    clk          = 1'b0;
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    req_taken    = 1'b0;
    gap_left     = 0;
    burst_left   = 1;
    sink_mode    = SINK_ALWAYS;
    mode_left    = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    roots_checked = 0;
    negative_ops = 0;
    error_count  = 0;

    foreach (corner_values[i]) pending_values.push_back(corner_values[i]);
    for (int n = 0; n < RANDOM_OPERANDS; n++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom();
        1: begin
          // perfect squares and their neighbors
          k = $urandom_range(0, 46340);
          v = k * k + 32'($urandom_range(0, 2)) - 32'd1;
          if (k == 0 && v == 32'hFFFF_FFFF) v = 32'd0;
        end
        2: v = $urandom() >> $urandom_range(0, 31);
        default: v = $urandom_range(0, 1000);
      endcase
      pending_values.push_back(signed'(v));
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    do @(negedge clk); while (pending_values.size() > 0 || expected_roots.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d roots over %0d operands (%0d negative), %0d mismatches.",
             roots_checked, corner_values.size() + RANDOM_OPERANDS, negative_ops,
             error_count);
    if (error_count == 0) begin
      $display("** integer_square_root: PASSED **");
    end else begin
      $display("** integer_square_root: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timed out with %0d roots still expected.", expected_roots.size());
    $display("** integer_square_root: FAILED **");
    $finish;
  end

endmodule
